// ===== src/ccur_pkg.sv =====
// Shared types and constants of the text console cursor engine.
package ccur_pkg;

  // Default geometry.
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;
  localparam int QUEUE_DEPTH  = 2;

  // Field widths of the channels.
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 8;
  localparam int CELL_IDX_W = 11;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_LOC_W  = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_ATTR  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_ATTR = 1'd1;
  localparam logic [ATTR_W-1:0] CHAR_ATTR_RST  = 8'h02;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h0F;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Character codes.
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_LAST  = 8'h7F;

  // Decoded operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [CODE_W-1:0]     code;
    logic [CELL_IDX_W-1:0] cell_index;
  } cmd_t;

endpackage

// ===== src/ccur_cmd_if.sv =====
// Input channel: one console item per word.
interface ccur_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [ccur_pkg::KIND_W-1:0]      kind;
  logic [ccur_pkg::CODE_W-1:0]      char_code;
  logic [ccur_pkg::CELL_IDX_W-1:0]  cell_index;

  modport source(output valid, kind, char_code, cell_index, input ready);
  modport sink(input valid, kind, char_code, cell_index, output ready);
endinterface

// ===== src/ccur_rsp_if.sv =====
// Output channel: cursor and cell data, one word per item.
interface ccur_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ccur_pkg::OUT_COL_W-1:0]  cursor_column;
  logic [ccur_pkg::OUT_ROW_W-1:0]  cursor_row;
  logic [ccur_pkg::OUT_LOC_W-1:0]  cursor_location;
  logic [ccur_pkg::CELL_W-1:0]     cell_data;

  modport source(output valid, cursor_column, cursor_row, cursor_location, cell_data,
                 input ready);
  modport sink(input valid, cursor_column, cursor_row, cursor_location, cell_data,
               output ready);
endinterface

// ===== src/ccur_front.sv =====
// Front: accepts input words and decodes them into console operations.
module ccur_front (
  input  logic               clk,
  input  logic               rst,
  ccur_cmd_if.sink           cmd,
  input  logic               enable,
  output ccur_pkg::cmd_t     q_data,
  output logic               q_valid,
  input  logic               q_ready
);

  ccur_pkg::cmd_t  hold;
  logic            hold_valid;
  ccur_pkg::op_t   op_dec;

  always_comb begin
    op_dec = ccur_pkg::OP_NOP;
    case (cmd.kind)
      ccur_pkg::KIND_PUT: begin
        if (cmd.char_code == ccur_pkg::CH_BS) begin
          op_dec = ccur_pkg::OP_BS;
        end else if (cmd.char_code == ccur_pkg::CH_TAB) begin
          op_dec = ccur_pkg::OP_TAB;
        end else if (cmd.char_code == ccur_pkg::CH_CR) begin
          op_dec = ccur_pkg::OP_CR;
        end else if (cmd.char_code == ccur_pkg::CH_LF) begin
          op_dec = ccur_pkg::OP_LF;
        end else if (cmd.char_code >= ccur_pkg::CH_SPACE &&
                     cmd.char_code <= ccur_pkg::CH_LAST) begin
          op_dec = ccur_pkg::OP_PRINT;
        end
      end
      ccur_pkg::KIND_CLEAR: op_dec = ccur_pkg::OP_CLEAR;
      ccur_pkg::KIND_READ:  op_dec = ccur_pkg::OP_READ;
      default:              op_dec = ccur_pkg::OP_NOP;
    endcase
  end

  assign cmd.ready = enable && (!hold_valid || q_ready);
  assign q_data    = hold;
  assign q_valid   = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      hold_valid <= 1'b1;
    end else if (q_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      hold.op         <= op_dec;
      hold.code       <= cmd.char_code;
      hold.cell_index <= cmd.cell_index;
    end
  end

endmodule

// ===== src/ccur_fifo.sv =====
// Short queue of decoded operations between front and back.
module ccur_fifo #(
  parameter int DEPTH = ccur_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  ccur_pkg::cmd_t  wr_data,
  input  logic            wr_valid,
  output logic            wr_ready,
  output ccur_pkg::cmd_t  rd_data,
  output logic            rd_valid,
  input  logic            rd_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccur_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== src/ccur_back.sv =====
// Back: cell store with rotating row base, cursor, sweeps and result register.
module ccur_back #(
  parameter int COLUMNS  = ccur_pkg::COLUMNS_DEF,
  parameter int ROWS     = ccur_pkg::ROWS_DEF,
  parameter int TAB_STOP = ccur_pkg::TAB_STOP_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ccur_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ccur_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ccur_pkg::cmd_t                     q_data,
  input  logic                               q_valid,
  output logic                               q_ready,
  output logic                               init_busy,
  ccur_rsp_if.source                         rsp
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LIN_W  = $clog2(CELL_COUNT);
  localparam int IDX_W  = ccur_pkg::CELL_IDX_W;
  localparam int SUM_W  = ((LIN_W > IDX_W) ? LIN_W : IDX_W) + 1;
  localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_STOP);
  localparam int EXT_W  = SUM_W + COL_W + ROW_W + 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_READ_WAIT,
    S_REPLY
  } state_t;

  state_t                          state;
  logic                            init;
  logic [COL_W-1:0]                col;
  logic [ROW_W-1:0]                row;
  logic [PH_W-1:0]                 phase;
  logic [LIN_W-1:0]                base_off;
  logic [LIN_W-1:0]                sw_addr;
  logic [LIN_W-1:0]                sw_last;
  logic [LIN_W-1:0]                rd_addr;
  logic                            reply_read;
  logic [ccur_pkg::ATTR_W-1:0]     char_attr;
  logic [ccur_pkg::ATTR_W-1:0]     blank_attr;
  logic [ccur_pkg::CELL_W-1:0]     mem [CELL_COUNT];
  logic [ccur_pkg::CELL_W-1:0]     rd_data;

  logic [ccur_pkg::CELL_W-1:0]     blank_cell;
  logic [LIN_W-1:0]                lin_cur;
  logic [LIN_W:0]                  wsum;
  logic [LIN_W-1:0]                put_addr;
  logic [SUM_W-1:0]                rsum;
  logic [LIN_W-1:0]                read_addr;
  logic                            read_ok;
  logic [LIN_W-1:0]                base_next;

  logic [COL_W-1:0]                col_a;
  logic [PH_W-1:0]                 ph_a;
  logic                            feed;
  logic [COL_W-1:0]                col_next;
  logic [ROW_W-1:0]                row_next;
  logic [PH_W-1:0]                 phase_next;
  logic                            scroll;

  logic                            mem_we;
  logic [LIN_W-1:0]                mem_waddr;
  logic [ccur_pkg::CELL_W-1:0]     mem_wdata;

  logic                            take;

  assign q_ready   = (state == S_IDLE) && !init;
  assign init_busy = init;
  assign take      = q_valid && q_ready;

  // Reset sweep always uses the reset attribute.
  assign blank_cell = {(init ? ccur_pkg::BLANK_ATTR_RST : blank_attr), ccur_pkg::CH_SPACE};

  // Logical cursor location and its physical address in the rotated store.
  assign lin_cur  = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  assign wsum     = {1'b0, lin_cur} + {1'b0, base_off};
  assign put_addr = (wsum >= (LIN_W+1)'(CELL_COUNT)) ?
                    LIN_W'(wsum - (LIN_W+1)'(CELL_COUNT)) : LIN_W'(wsum);

  assign rsum      = SUM_W'(q_data.cell_index) + SUM_W'(base_off);
  assign read_addr = (rsum >= SUM_W'(CELL_COUNT)) ?
                     LIN_W'(rsum - SUM_W'(CELL_COUNT)) : LIN_W'(rsum);
  assign read_ok   = (SUM_W'(q_data.cell_index) < SUM_W'(CELL_COUNT));

  assign base_next = (base_off == LIN_W'(CELL_COUNT - COLUMNS)) ?
                     '0 : base_off + LIN_W'(COLUMNS);

  // Cursor motion of a put operation.
  always_comb begin
    col_a = col;
    ph_a  = phase;
    feed  = 1'b0;
    case (q_data.op)
      ccur_pkg::OP_PRINT: begin
        col_a = col + 1'b1;
        ph_a  = (phase == PH_W'(TAB_STOP - 1)) ? '0 : phase + 1'b1;
      end
      ccur_pkg::OP_BS: begin
        if (col != '0) begin
          col_a = col - 1'b1;
          ph_a  = (phase == '0) ? PH_W'(TAB_STOP - 1) : phase - 1'b1;
        end
      end
      ccur_pkg::OP_TAB: begin
        col_a = col + COL_W'(TAB_STOP) - COL_W'(phase);
        ph_a  = '0;
      end
      ccur_pkg::OP_CR: begin
        col_a = '0;
        ph_a  = '0;
      end
      ccur_pkg::OP_LF: begin
        col_a = '0;
        ph_a  = '0;
        feed  = 1'b1;
      end
      default: begin
        col_a = col;
        ph_a  = phase;
      end
    endcase

    col_next   = col_a;
    phase_next = ph_a;
    if (col_a >= COL_W'(COLUMNS)) begin
      col_next   = '0;
      phase_next = '0;
      feed       = 1'b1;
    end

    row_next = row;
    scroll   = 1'b0;
    if (feed) begin
      if (row == ROW_W'(ROWS - 1)) begin
        scroll = 1'b1;
      end else begin
        row_next = row + 1'b1;
      end
    end
  end

  // Store write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = put_addr;
    mem_wdata = {char_attr, q_data.code};
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sw_addr;
      mem_wdata = blank_cell;
    end else if (take && q_data.op == ccur_pkg::OP_PRINT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attr  <= ccur_pkg::CHAR_ATTR_RST;
      blank_attr <= ccur_pkg::BLANK_ATTR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ccur_pkg::CFG_CHAR_ATTR:  char_attr  <= cfg_data;
        ccur_pkg::CFG_BLANK_ATTR: blank_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      init       <= 1'b1;
      col        <= '0;
      row        <= '0;
      phase      <= '0;
      base_off   <= '0;
      sw_addr    <= '0;
      sw_last    <= LIN_W'(CELL_COUNT - 1);
      rd_addr    <= '0;
      reply_read <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      // Drop the taken word unless a new one loads this cycle.
      if (rsp.ready && state != S_REPLY) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            reply_read <= 1'b0;
            case (q_data.op)
              ccur_pkg::OP_CLEAR: begin
                col      <= '0;
                row      <= '0;
                phase    <= '0;
                base_off <= '0;
                sw_addr  <= '0;
                sw_last  <= LIN_W'(CELL_COUNT - 1);
                state    <= S_SWEEP;
              end
              ccur_pkg::OP_READ: begin
                rd_addr    <= read_addr;
                reply_read <= read_ok;
                state      <= S_READ_WAIT;
              end
              default: begin
                col   <= col_next;
                row   <= row_next;
                phase <= phase_next;
                if (scroll) begin
                  // Old top row becomes the new bottom row: blank it.
                  sw_addr  <= base_off;
                  sw_last  <= base_off + LIN_W'(COLUMNS - 1);
                  base_off <= base_next;
                  state    <= S_SWEEP;
                end else begin
                  state <= S_REPLY;
                end
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (sw_addr == sw_last) begin
            if (init) begin
              init  <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_REPLY;
            end
          end else begin
            sw_addr <= sw_addr + 1'b1;
          end
        end
        S_READ_WAIT: begin
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.cursor_column   <= ccur_pkg::OUT_COL_W'(EXT_W'(col));
            rsp.cursor_row      <= ccur_pkg::OUT_ROW_W'(EXT_W'(row));
            rsp.cursor_location <= ccur_pkg::OUT_LOC_W'(EXT_W'(lin_cur));
            rsp.cell_data       <= reply_read ? rd_data : '0;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/text_console_cursor_engine_top.sv =====
// Top level of the text console cursor engine.
//
//   channel  dir  handshake     word
//   cmd      in   valid/ready   kind, char_code, cell_index
//   rsp      out  valid/ready   cursor_column, cursor_row, cursor_location, cell_data
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// Each word passes the decode register and the queue, then the back takes it.
// In the back a put or cursor move goes through S_REPLY, a read through S_READ_WAIT
// and S_REPLY (registered store read); a scroll blanks one row and a clear the
// whole store in a sweep through the one store write port before the reply.
// After reset the store is blanked with cmd.ready low.
// A stalled rsp holds the result; the queue keeps taking words until full.
module text_console_cursor_engine_top #(
  parameter int COLUMNS  = ccur_pkg::COLUMNS_DEF,
  parameter int ROWS     = ccur_pkg::ROWS_DEF,
  parameter int TAB_STOP = ccur_pkg::TAB_STOP_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  ccur_cmd_if.sink                           cmd,
  ccur_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [ccur_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ccur_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ccur_pkg::cmd_t  front_data;
  logic            front_valid;
  logic            front_ready;
  ccur_pkg::cmd_t  queue_data;
  logic            queue_valid;
  logic            queue_ready;
  logic            init_busy;

  ccur_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .enable  (!init_busy),
    .q_data  (front_data),
    .q_valid (front_valid),
    .q_ready (front_ready)
  );

  ccur_fifo #(
    .DEPTH (ccur_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_data),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_data  (queue_data),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  ccur_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_data    (queue_data),
    .q_valid   (queue_valid),
    .q_ready   (queue_ready),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the text console cursor engine: directed script, random text, checker.
module tb;

  localparam int COLUMNS  = ccur_pkg::COLUMNS_DEF;
  localparam int ROWS     = ccur_pkg::ROWS_DEF;
  localparam int TAB_STOP = ccur_pkg::TAB_STOP_DEF;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int CELL_IDX_MAX = (1 << ccur_pkg::CELL_IDX_W) - 1;
  localparam int MAX_IDLE  = 14;
  localparam int HOLD_OFF  = 400;
  localparam int PHASE_WORDS = 260;
  localparam int LIMIT = 1500000;
  localparam int MAX_PRINTS = 40;

  // Kind with no function; codes outside the handled set.
  localparam logic [ccur_pkg::KIND_W-1:0] KIND_NONE     = 2'd3;
  localparam logic [ccur_pkg::CODE_W-1:0] CH_NUL        = 8'h00;
  localparam logic [ccur_pkg::CODE_W-1:0] CH_ESC        = 8'h1B;
  localparam logic [ccur_pkg::CODE_W-1:0] CH_UNIT_SEP   = 8'h1F;
  localparam logic [ccur_pkg::CODE_W-1:0] CH_HIGH_FIRST = 8'h80;
  localparam logic [ccur_pkg::CODE_W-1:0] CH_HIGH_LAST  = 8'hFF;
  localparam logic [ccur_pkg::CELL_W-1:0] BLANK_CELL_RST =
    {ccur_pkg::BLANK_ATTR_RST, ccur_pkg::CH_SPACE};

  typedef struct packed {
    logic [ccur_pkg::OUT_COL_W-1:0] column;
    logic [ccur_pkg::OUT_ROW_W-1:0] row;
    logic [ccur_pkg::OUT_LOC_W-1:0] location;
    logic [ccur_pkg::CELL_W-1:0]    data;
  } console_word_t;

  typedef struct packed {
    logic [ccur_pkg::KIND_W-1:0]     kind;
    logic [ccur_pkg::CODE_W-1:0]     code;
    logic [ccur_pkg::CELL_IDX_W-1:0] cell_idx;
    logic [6:0]                      reps;
    logic                            typed;
    console_word_t                   word;
  } script_row_t;

  localparam console_word_t NO_WORD = '0;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ccur_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ccur_pkg::CFG_DATA_W-1:0]  cfg_data;

  ccur_cmd_if cmd_bus();
  ccur_rsp_if rsp_bus();

  text_console_cursor_engine_top DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the console: cell store, cursor and attributes.
  logic [ccur_pkg::CELL_W-1:0] shadow_cells [0:CELLS-1];
  int unsigned                 cur_col;
  int unsigned                 cur_row;
  logic [ccur_pkg::ATTR_W-1:0] char_attr;
  logic [ccur_pkg::ATTR_W-1:0] blank_attr;

  console_word_t pending_words [$];
  script_row_t   script [$];
  int unsigned   fail_count;
  int unsigned   useful_count;
  int unsigned   cycle_count;
  bit            steady;
  bit            hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (fail_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void blank_cells_from(input int unsigned first);
    for (int i = first; i < CELLS; i++) shadow_cells[i] = {blank_attr, ccur_pkg::CH_SPACE};
  endfunction

  function automatic void console_put(input logic [ccur_pkg::CODE_W-1:0] code);
    if (code == ccur_pkg::CH_BS) begin
      if (cur_col > 0) cur_col--;
    end else if (code == ccur_pkg::CH_TAB) begin
      cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
    end else if (code == ccur_pkg::CH_CR) begin
      cur_col = 0;
    end else if (code == ccur_pkg::CH_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (code >= ccur_pkg::CH_SPACE && code <= ccur_pkg::CH_LAST) begin
      shadow_cells[cur_row * COLUMNS + cur_col] = {char_attr, code};
      cur_col++;
    end
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    // Scroll up one row and blank the bottom row.
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      blank_cells_from(CELLS - COLUMNS);
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic console_word_t at_cursor(input int unsigned c, input int unsigned r,
                                              input logic [ccur_pkg::CELL_W-1:0] d);
    console_word_t w;
    w.column   = ccur_pkg::OUT_COL_W'(c);
    w.row      = ccur_pkg::OUT_ROW_W'(r);
    w.location = ccur_pkg::OUT_LOC_W'(r * COLUMNS + c);
    w.data     = d;
    return w;
  endfunction

  function automatic console_word_t console_step(
      input logic [ccur_pkg::KIND_W-1:0] kind,
      input logic [ccur_pkg::CODE_W-1:0] code,
      input logic [ccur_pkg::CELL_IDX_W-1:0] cell_idx);
    logic [ccur_pkg::CELL_W-1:0] d;
    d = '0;
    case (kind)
      ccur_pkg::KIND_PUT: console_put(code);
      ccur_pkg::KIND_CLEAR: begin
        blank_cells_from(0);
        cur_col = 0;
        cur_row = 0;
      end
      ccur_pkg::KIND_READ: begin
        if (cell_idx < CELLS) d = shadow_cells[cell_idx];
      end
      default: ;
    endcase
    return at_cursor(cur_col, cur_row, d);
  endfunction

  function automatic bit is_ignored(input logic [ccur_pkg::CODE_W-1:0] code);
    return code >= CH_HIGH_FIRST ||
           (code < ccur_pkg::CH_SPACE && code != ccur_pkg::CH_BS &&
            code != ccur_pkg::CH_TAB && code != ccur_pkg::CH_CR &&
            code != ccur_pkg::CH_LF);
  endfunction

  function automatic script_row_t step_row(input logic [ccur_pkg::KIND_W-1:0] kind,
                                           input logic [ccur_pkg::CODE_W-1:0] code,
                                           input int unsigned cell_idx,
                                           input int unsigned reps,
                                           input bit typed, input console_word_t word);
    script_row_t s;
    s.kind     = kind;
    s.code     = code;
    s.cell_idx = ccur_pkg::CELL_IDX_W'(cell_idx);
    s.reps     = 7'(reps);
    s.typed    = typed;
    s.word     = word;
    return s;
  endfunction

  function automatic logic [ccur_pkg::CODE_W-1:0] any_code();
    return ccur_pkg::CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ccur_pkg::CELL_IDX_W-1:0] any_index();
    return ccur_pkg::CELL_IDX_W'($urandom_range(0, CELL_IDX_MAX));
  endfunction

  task automatic send_word(input logic [ccur_pkg::KIND_W-1:0] kind,
                           input logic [ccur_pkg::CODE_W-1:0] code,
                           input logic [ccur_pkg::CELL_IDX_W-1:0] cell_idx, input bit typed,
                           input console_word_t typed_word);
    int unsigned gap;
    console_word_t w;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.kind       <= kind;
    cmd_bus.char_code  <= code;
    cmd_bus.cell_index <= cell_idx;
    do @(posedge clk); while (!cmd_bus.ready);
    w = console_step(kind, code, cell_idx);
    if (typed) w = typed_word;
    pending_words.push_back(w);
    if (!(kind == ccur_pkg::KIND_PUT && is_ignored(code))) useful_count++;
  endtask

  task automatic send_plain(input logic [ccur_pkg::KIND_W-1:0] kind,
                            input logic [ccur_pkg::CODE_W-1:0] code,
                            input logic [ccur_pkg::CELL_IDX_W-1:0] cell_idx);
    send_word(kind, code, cell_idx, 1'b0, NO_WORD);
  endtask

  // Drop valid, drain, then let any sweep behind the last word finish.
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (CELLS + 16) @(posedge clk);
  endtask

  task automatic write_attrs(input logic [ccur_pkg::ATTR_W-1:0] ca,
                             input logic [ccur_pkg::ATTR_W-1:0] ba);
    cfg_we    <= 1'b1;
    cfg_index <= ccur_pkg::CFG_CHAR_ATTR;
    cfg_data  <= ca;
    @(posedge clk);
    cfg_index <= ccur_pkg::CFG_BLANK_ATTR;
    cfg_data  <= ba;
    @(posedge clk);
    cfg_we     <= 1'b0;
    char_attr  = ca;
    blank_attr = ba;
  endtask

  function automatic logic [ccur_pkg::CODE_W-1:0] text_code();
    int unsigned p;
    p = $urandom_range(0, 19);
    case (p)
      0: return ccur_pkg::CH_TAB;
      1: return ccur_pkg::CH_BS;
      2: return ccur_pkg::CH_CR;
      3: return ccur_pkg::CODE_W'($urandom_range(0, 1) ?
                                  $urandom_range(CH_NUL, CH_UNIT_SEP) :
                                  $urandom_range(CH_HIGH_FIRST, CH_HIGH_LAST));
      default: return ccur_pkg::CODE_W'($urandom_range(ccur_pkg::CH_SPACE, ccur_pkg::CH_LAST));
    endcase
  endfunction

  task automatic run_text(input int unsigned target);
    int unsigned start_count;
    int unsigned r;
    int unsigned n;
    int unsigned idx;
    start_count = useful_count;
    while (useful_count - start_count < target) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(0, 90);
        for (int i = 0; i < n; i++) send_plain(ccur_pkg::KIND_PUT, text_code(), any_index());
        if ($urandom_range(0, 4) != 0)
          send_plain(ccur_pkg::KIND_PUT, ccur_pkg::CH_LF, any_index());
      end else if (r < 80) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          idx = $urandom_range(0, 1) ? cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)
                                     : $urandom_range(0, CELL_IDX_MAX);
          send_plain(ccur_pkg::KIND_READ, any_code(), ccur_pkg::CELL_IDX_W'(idx));
        end
      end else if (r < 88) begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
          send_plain(ccur_pkg::KIND_PUT, ccur_pkg::CH_LF, any_index());
      end else if (r < 92) begin
        send_plain(KIND_NONE, any_code(), any_index());
      end else if (r < 97) begin
        send_plain(ccur_pkg::KIND_PUT, any_code(), any_index());
      end else if (r == 97 && $urandom_range(0, 2) == 0) begin
        send_plain(ccur_pkg::KIND_CLEAR, any_code(), any_index());
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_plain(ccur_pkg::KIND_PUT,
                     $urandom_range(0, 1) ? ccur_pkg::CH_TAB : ccur_pkg::CH_BS, '0);
      end
    end
  endtask

  task automatic run_phase(input logic [ccur_pkg::ATTR_W-1:0] ca,
                           input logic [ccur_pkg::ATTR_W-1:0] ba, input bit hold);
    settle();
    write_attrs(ca, ba);
    hold_req = hold;
    // Old cells keep the attributes they were written with.
    for (int i = 0; i < 3; i++)
      send_plain(ccur_pkg::KIND_READ, CH_NUL,
                 ccur_pkg::CELL_IDX_W'($urandom_range(0, CELLS - 1)));
    send_plain(ccur_pkg::KIND_CLEAR, CH_NUL, '0);
    run_text(PHASE_WORDS);
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  initial begin : rsp_side
    int unsigned stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  always @(posedge clk) begin : rsp_check
    console_word_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word", 32'(rsp_bus.cursor_location), 0);
      end else begin
        want = pending_words.pop_front();
        if (rsp_bus.cursor_column !== want.column)
          flag_mismatch("cursor_column", 32'(rsp_bus.cursor_column), 32'(want.column));
        if (rsp_bus.cursor_row !== want.row)
          flag_mismatch("cursor_row", 32'(rsp_bus.cursor_row), 32'(want.row));
        if (rsp_bus.cursor_location !== want.location)
          flag_mismatch("cursor_location", 32'(rsp_bus.cursor_location),
                        32'(want.location));
        if (rsp_bus.cell_data !== want.data)
          flag_mismatch("cell_data", 32'(rsp_bus.cell_data), 32'(want.data));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("text_console_cursor_engine_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    cycle_count = 0;
    fail_count = 0;
    useful_count = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= ccur_pkg::CFG_CHAR_ATTR;
    cfg_data <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.kind <= ccur_pkg::KIND_PUT;
    cmd_bus.char_code <= CH_NUL;
    cmd_bus.cell_index <= '0;
    char_attr  = ccur_pkg::CHAR_ATTR_RST;
    blank_attr = ccur_pkg::BLANK_ATTR_RST;
    blank_cells_from(0);
    cur_col = 0;
    cur_row = 0;

    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, 0, 1, 1,
                              at_cursor(0, 0, BLANK_CELL_RST)));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, CELLS - 1, 1, 1,
                              at_cursor(0, 0, BLANK_CELL_RST)));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, CELLS, 1, 1, at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_HIGH_LAST, CELL_IDX_MAX, 1, 1,
                              at_cursor(0, 0, 0)));
    script.push_back(step_row(KIND_NONE, CH_HIGH_LAST, CELL_IDX_MAX, 1, 1,
                              at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_BS, 0, 1, 1,
                              at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, CH_NUL, 0, 1, 1, at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, CH_ESC, 0, 1, 1, at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, CH_HIGH_FIRST, 0, 1, 1,
                              at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, CH_HIGH_LAST, CELL_IDX_MAX, 1, 1,
                              at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_SPACE, 0, 1, 1,
                              at_cursor(1, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_LAST, 0, 1, 1,
                              at_cursor(2, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_PUT, 8'h41, 0, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_TAB, 0, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_BS, 0, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_CR, 0, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, 2, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_LF, 0, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_CLEAR, CH_NUL, 0, 1, 1, at_cursor(0, 0, 0)));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, 1, 1, 1,
                              at_cursor(0, 0, BLANK_CELL_RST)));
    // Tab to the last stop, then print past the right edge.
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_TAB, 0, 9, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, 8'h5A, 0, 8, 0, NO_WORD));
    // Tab past the right edge, walk to the bottom, tab past it again to scroll.
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_TAB, 0, 10, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_LF, 0, 22, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_TAB, 0, 10, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_PUT, ccur_pkg::CH_LF, 0, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, CELLS - COLUMNS, 1, 0, NO_WORD));
    script.push_back(step_row(ccur_pkg::KIND_READ, CH_NUL, 0, 1, 0, NO_WORD));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      for (int k = 0; k < script[i].reps; k++)
        send_word(script[i].kind, script[i].code, script[i].cell_idx, script[i].typed,
                  script[i].word);

    run_phase(8'h00, 8'h00, 1'b1);
    run_phase(8'hFF, 8'hFF, 1'b0);
    run_phase(ccur_pkg::ATTR_W'($urandom_range(0, 255)),
              ccur_pkg::ATTR_W'($urandom_range(0, 255)), 1'b1);
    run_phase(8'hFF, 8'h00, 1'b0);
    run_phase(ccur_pkg::CHAR_ATTR_RST, ccur_pkg::BLANK_ATTR_RST, 1'b0);

    cmd_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (CELLS + 16) @(posedge clk);
    if (pending_words.size() != 0) flag_mismatch("words never returned", 0, pending_words.size());
    if (fail_count == 0) begin
      $display("text_console_cursor_engine_top test passed");
    end else begin
      $display("text_console_cursor_engine_top test failed");
    end
    $finish;
  end

endmodule
